// ===== rtl/qmn_pkg.sv =====
// Package for the quaternion multiply/normalize core: payload structs and widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package qmn_pkg;
  localparam int FRAC_BITS = 30;
  localparam int WORD_W = 32;
  localparam int MAG_W = 64;
  localparam int FIT_W = 30;
  localparam int N2_W = 62;
  localparam int ROOT_W = 31;
  localparam int DIV_W = FIT_W + FRAC_BITS + 1;

  typedef struct packed {
    logic signed [31:0] left_w;
    logic signed [31:0] left_x;
    logic signed [31:0] left_y;
    logic signed [31:0] left_z;
    logic signed [31:0] right_w;
    logic signed [31:0] right_x;
    logic signed [31:0] right_y;
    logic signed [31:0] right_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0] prod_w;
    logic signed [31:0] prod_x;
    logic signed [31:0] prod_y;
    logic signed [31:0] prod_z;
    logic zero_norm;
  } out_t;
endpackage
`default_nettype wire

// ===== rtl/quaternion_multiply_normalize_core.sv =====
// Quaternion Hamilton product normalized to unit length; Q2.30 in and out.
// One transfer accepted per cycle; busy is held low and the receiver cannot stall.
// Synchronous active-high rst clears all valid bits; payload is not reset.
// Pipeline: 7 arithmetic stages, 8 root stages, 8 divide stages and the output register.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_multiply_normalize_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  output logic                busy,
  input  wire qmn_pkg::in_t   in_data,
  output logic                done,
  output qmn_pkg::out_t       out_data
);
  localparam int MW = qmn_pkg::MAG_W;
  localparam int FW = qmn_pkg::FIT_W;
  localparam int RW = qmn_pkg::ROOT_W;
  localparam int DW = qmn_pkg::DIV_W;
  localparam int DSTEPS = DW;
  localparam int DPER = 8;
  localparam int DSTG = (DSTEPS + DPER - 1) / DPER;

  assign busy = 1'b0;

  // stage 1: magnitudes and 16 products
  logic [7:0][31:0] a_mag;
  logic [7:0]       a_neg;
  logic [31:0]      raw [8];
  always_comb begin
    raw[0] = in_data.left_w;  raw[1] = in_data.left_x;
    raw[2] = in_data.left_y;  raw[3] = in_data.left_z;
    raw[4] = in_data.right_w; raw[5] = in_data.right_x;
    raw[6] = in_data.right_y; raw[7] = in_data.right_z;
    for (int i = 0; i < 8; i++) begin
      a_neg[i] = raw[i][31];
      a_mag[i] = raw[i][31] ? (~raw[i] + 32'd1) : raw[i];
    end
  end

  localparam logic [2:0] LI [16] = '{3'd0, 3'd1, 3'd2, 3'd3, 3'd1, 3'd0, 3'd2, 3'd3,
                                      3'd2, 3'd0, 3'd3, 3'd1, 3'd3, 3'd0, 3'd1, 3'd2};
  localparam logic [2:0] RI [16] = '{3'd4, 3'd5, 3'd6, 3'd7, 3'd4, 3'd5, 3'd7, 3'd6,
                                      3'd4, 3'd6, 3'd5, 3'd7, 3'd4, 3'd7, 3'd6, 3'd5};
  localparam logic       SB [16] = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1,
                                      1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1};

  logic              v1;
  logic [15:0][63:0] p1;
  logic [15:0]       n1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= start;
    for (int t = 0; t < 16; t++) begin
      p1[t] <= 64'(a_mag[LI[t]]) * 64'(a_mag[RI[t]]);
      n1[t] <= (a_neg[LI[t]] ^ a_neg[RI[t]]) ^ SB[t];
    end
  end

  // stage 2: positive and negative sums
  logic             v2;
  logic [3:0][MW-1:0] ps2, ns2;
  always_ff @(posedge clk) begin
    logic [MW-1:0] ps, ns;
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    for (int c = 0; c < 4; c++) begin
      ps = '0; ns = '0;
      for (int t = 0; t < 4; t++) begin
        if (n1[c*4+t]) ns = ns + p1[c*4+t];
        else ps = ps + p1[c*4+t];
      end
      ps2[c] <= ps;
      ns2[c] <= ns;
    end
  end

  // stage 3: signed magnitude
  logic               v3;
  logic [3:0][MW-1:0] m3;
  logic [3:0]         g3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    for (int c = 0; c < 4; c++) begin
      g3[c] <= ps2[c] < ns2[c];
      m3[c] <= (ps2[c] >= ns2[c]) ? ps2[c] - ns2[c] : ns2[c] - ps2[c];
    end
  end

  // stage 4: shift amount from OR of magnitudes
  logic               v4;
  logic [3:0][MW-1:0] m4;
  logic [3:0]         g4;
  logic [5:0]         s4;
  logic               z4;
  always_ff @(posedge clk) begin
    logic [MW-1:0] orv;
    logic [5:0]    s;
    orv = m3[0] | m3[1] | m3[2] | m3[3];
    s = '0;
    for (int b = FW; b < MW; b++) begin
      if (orv[b]) s = 6'(b - FW + 1);
    end
    if (rst) v4 <= 1'b0;
    else v4 <= v3;
    m4 <= m3;
    g4 <= g3;
    s4 <= s;
    z4 <= (orv == '0);
  end

  // stage 5: shift
  logic               v5;
  logic [3:0][FW-1:0] m5;
  logic [3:0]         g5;
  logic               z5;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else v5 <= v4;
    for (int c = 0; c < 4; c++) m5[c] <= FW'(m4[c] >> s4);
    g5 <= g4;
    z5 <= z4;
  end

  // stage 6: squares
  logic               v6;
  logic [3:0][2*FW-1:0] q6;
  logic [3:0][FW-1:0] m6;
  logic [3:0]         g6;
  logic               z6;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else v6 <= v5;
    for (int c = 0; c < 4; c++) q6[c] <= m5[c] * m5[c];
    m6 <= m5; g6 <= g5; z6 <= z5;
  end

  // stage 7: sum of squares
  logic                     v7;
  logic [qmn_pkg::N2_W-1:0] n27;
  logic [3:0][FW-1:0]       m7;
  logic [3:0]               g7;
  logic                     z7;
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else v7 <= v6;
    n27 <= qmn_pkg::N2_W'(q6[0]) + qmn_pkg::N2_W'(q6[1]) +
           qmn_pkg::N2_W'(q6[2]) + qmn_pkg::N2_W'(q6[3]);
    m7 <= m6; g7 <= g6; z7 <= z6;
  end

  // square root
  logic               v8;
  logic [RW-1:0]      rt8;
  logic [3:0][FW-1:0] m8;
  logic [3:0]         g8;
  logic               z8;
  qmn_sqrt u_sqrt (
    .clk(clk), .rst(rst), .in_valid(v7), .n2(n27), .m_in(m7), .neg_in(g7),
    .zero_in(z7), .out_valid(v8), .root(rt8), .m_out(m8), .neg_out(g8),
    .zero_out(z8)
  );

  // restoring divide pipeline, four lanes share divisor
  logic                   dv   [DSTG+1];
  logic [3:0][DW-1:0]     dnum [DSTG+1];
  logic [3:0][RW:0]       drem [DSTG+1];
  logic [3:0][DW-1:0]     dquo [DSTG+1];
  logic [RW-1:0]          dden [DSTG+1];
  logic [3:0]             dneg [DSTG+1];
  logic                   dzr  [DSTG+1];

  always_comb begin
    logic [RW-1:0] n;
    n = (rt8 == '0) ? RW'(1) : rt8;
    dv[0] = v8;
    dden[0] = n;
    dneg[0] = g8;
    dzr[0] = z8;
    for (int c = 0; c < 4; c++) begin
      dnum[0][c] = (DW'(m8[c]) << qmn_pkg::FRAC_BITS) + DW'(n >> 1);
      drem[0][c] = '0;
      dquo[0][c] = '0;
    end
  end

  for (genvar g = 0; g < DSTG; g++) begin : g_div
    logic [3:0][DW-1:0] nn, qq;
    logic [3:0][RW:0]   rr;
    always_comb begin
      logic [RW+1:0] tr;
      tr = '0;
      nn = dnum[g]; qq = dquo[g]; rr = drem[g];
      for (int c = 0; c < 4; c++) begin
        for (int k = 0; k < DPER; k++) begin
          if (g * DPER + k < DSTEPS) begin
            tr = {rr[c], nn[c][DW-1]};
            nn[c] = {nn[c][DW-2:0], 1'b0};
            if (tr >= {1'b0, 1'b0, dden[g]}) begin
              tr = tr - {2'b00, dden[g]};
              qq[c] = {qq[c][DW-2:0], 1'b1};
            end else begin
              qq[c] = {qq[c][DW-2:0], 1'b0};
            end
            rr[c] = tr[RW:0];
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) dv[g+1] <= 1'b0;
      else dv[g+1] <= dv[g];
      dnum[g+1] <= nn; dquo[g+1] <= qq; drem[g+1] <= rr;
      dden[g+1] <= dden[g]; dneg[g+1] <= dneg[g]; dzr[g+1] <= dzr[g];
    end
  end

  // output register with saturation and sign
  logic [3:0][31:0] res;
  always_comb begin
    logic [DW-1:0] q;
    for (int c = 0; c < 4; c++) begin
      q = dquo[DSTG][c];
      if (dzr[DSTG]) begin
        res[c] = '0;
      end else if (dneg[DSTG][c]) begin
        if (q > DW'(64'h8000_0000)) q = DW'(64'h8000_0000);
        res[c] = 32'(~q + DW'(1));
      end else begin
        if (q > DW'(64'h7FFF_FFFF)) q = DW'(64'h7FFF_FFFF);
        res[c] = q[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= dv[DSTG];
    out_data.prod_w <= res[0];
    out_data.prod_x <= res[1];
    out_data.prod_y <= res[2];
    out_data.prod_z <= res[3];
    out_data.zero_norm <= dzr[DSTG];
  end

`ifndef SYNTHESIS
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    done && out_data.zero_norm |-> out_data.prod_w == 0 && out_data.prod_x == 0)
    else $error("zero_norm with nonzero output");
  a_v_chain: assert property (@(posedge clk) disable iff (rst)
    v1 |=> v2) else $error("valid lost between stages");
  a_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
`endif
endmodule
`default_nettype wire

// ===== rtl/qmn_sqrt.sv =====
// Pipelined integer square root, up to four result bits per stage.
// Carries four component magnitudes and signs alongside. Uses qmn_pkg.
`timescale 1ns / 1ps
`default_nettype none
module qmn_sqrt (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  input  wire logic [qmn_pkg::N2_W-1:0]             n2,
  input  wire logic [3:0][qmn_pkg::FIT_W-1:0]       m_in,
  input  wire logic [3:0]                           neg_in,
  input  wire logic                                 zero_in,
  output logic                                      out_valid,
  output logic [qmn_pkg::ROOT_W-1:0]                root,
  output logic [3:0][qmn_pkg::FIT_W-1:0]            m_out,
  output logic [3:0]                                neg_out,
  output logic                                      zero_out
);
  localparam int STAGES = 8;
  localparam int BITS_PER = 4;
  localparam int STEPS = qmn_pkg::N2_W / 2;

  logic                               vld [STAGES+1];
  logic [qmn_pkg::N2_W-1:0]           rem [STAGES+1];
  logic [qmn_pkg::N2_W-1:0]           src [STAGES+1];
  logic [qmn_pkg::ROOT_W-1:0]         res [STAGES+1];
  logic [3:0][qmn_pkg::FIT_W-1:0]     mm  [STAGES+1];
  logic [3:0]                         ng  [STAGES+1];
  logic                               zr  [STAGES+1];

  assign vld[0] = in_valid;
  assign rem[0] = '0;
  assign src[0] = n2;
  assign res[0] = '0;
  assign mm[0]  = m_in;
  assign ng[0]  = neg_in;
  assign zr[0]  = zero_in;

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic [qmn_pkg::N2_W-1:0]   r_c, s_c;
    logic [qmn_pkg::ROOT_W-1:0] q_c;
    always_comb begin
      logic [qmn_pkg::N2_W+1:0] trial;
      logic [1:0]               pair;
      trial = '0;
      pair = '0;
      r_c = rem[g];
      s_c = src[g];
      q_c = res[g];
      for (int k = 0; k < BITS_PER; k++) begin
        if (g * BITS_PER + k < STEPS) begin
          pair = s_c[qmn_pkg::N2_W-1 -: 2];
          trial = {r_c, pair} - {q_c, 2'b01};
          s_c = {s_c[qmn_pkg::N2_W-3:0], 2'b00};
          if (!trial[qmn_pkg::N2_W+1]) begin
            r_c = trial[qmn_pkg::N2_W-1:0];
            q_c = {q_c[qmn_pkg::ROOT_W-2:0], 1'b1};
          end else begin
            r_c = {r_c[qmn_pkg::N2_W-3:0], pair};
            q_c = {q_c[qmn_pkg::ROOT_W-2:0], 1'b0};
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else begin
        vld[g+1] <= vld[g];
      end
      rem[g+1] <= r_c;
      src[g+1] <= s_c;
      res[g+1] <= q_c;
      mm[g+1]  <= mm[g];
      ng[g+1]  <= ng[g];
      zr[g+1]  <= zr[g];
    end
  end

  assign out_valid = vld[STAGES];
  assign root      = res[STAGES];
  assign m_out     = mm[STAGES];
  assign neg_out   = ng[STAGES];
  assign zero_out  = zr[STAGES];
endmodule
`default_nettype wire
